/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL
// Small wrappers that keep every check clocked and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside reset.
`define SS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked on the following edge.
`define SS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/sst_pkg.sv */
// ----------------------------------------------------------------------------
// sst_pkg
// Types and constants of the sorted set table.
// ----------------------------------------------------------------------------
package sst_pkg;

	localparam int CAPACITY   = 64;
	localparam int VALUE_BITS = 8;
	localparam int ADDR_BITS  = $clog2(CAPACITY);
	localparam int CNT_BITS   = $clog2(CAPACITY + 1);

	localparam logic [2:0] MODE_INSERT = 3'd0;
	localparam logic [2:0] MODE_REMOVE = 3'd1;
	localparam logic [2:0] MODE_POP    = 3'd2;
	localparam logic [2:0] MODE_MEMBER = 3'd3;
	localparam logic [2:0] MODE_READ   = 3'd4;
	localparam logic [2:0] MODE_COUNT  = 3'd5;

	localparam logic [1:0] ST_DONE   = 2'd0;
	localparam logic [1:0] ST_REJECT = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;

	typedef struct packed {
		logic [2:0]            mode;
		logic [VALUE_BITS-1:0] item_value;
		logic [5:0]            item_index;
	} req_t;

	typedef struct packed {
		logic [1:0]            status;
		logic                  hit;
		logic [VALUE_BITS-1:0] result_value;
		logic [6:0]            count_now;
	} rsp_t;

	typedef struct packed {
		logic                  en;
		logic [ADDR_BITS-1:0]  addr;
		logic [VALUE_BITS-1:0] data;
	} wr_t;

endpackage

/* rtl/core/sst_ram.sv */
// ----------------------------------------------------------------------------
// sst_ram
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sst_ram
	import sst_pkg::*;
(
	input  logic                  clk,
	input  wr_t                   wr,
	input  logic [ADDR_BITS-1:0]  rd_addr,
	output logic [VALUE_BITS-1:0] rd_data
);

	logic [VALUE_BITS-1:0] mem [CAPACITY];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

/* rtl/core/sst_ctrl.sv */
// ----------------------------------------------------------------------------
// sst_ctrl
// Sequencer: binary search, shifts and reads over the entry store.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sst_ctrl
	import sst_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  req_t                  req,
	input  logic                  req_valid,
	output logic                  req_ready,
	output rsp_t                  res,
	output logic                  res_valid,
	input  logic                  res_ready,
	output wr_t                   wr,
	output logic [ADDR_BITS-1:0]  rd_addr,
	input  logic [VALUE_BITS-1:0] rd_data
);

	typedef enum logic [3:0] {
		S_IDLE, S_SRCH_RD, S_SRCH_CMP, S_DECIDE, S_INS, S_INS_WR,
		S_REM, S_REM_WR, S_POP_WAIT, S_RD_WAIT, S_FINISH
	} state_t;

	state_t                state_q;
	logic [2:0]            mode_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [CNT_BITS-1:0]   lo_q, hi_q, k_q, count_q;
	logic                  found_q;
	logic [1:0]            status_q;
	logic                  hit_q;
	logic [VALUE_BITS-1:0] rv_q;

	logic [CNT_BITS:0]     sum;
	logic [CNT_BITS-1:0]   mid;
	logic [CNT_BITS-1:0]   k_dn, k_up;

	assign sum  = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid  = sum[CNT_BITS:1];
	assign k_dn = k_q - CNT_BITS'(1);
	assign k_up = k_q + CNT_BITS'(1);

	assign req_ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_FINISH);
	assign res.status       = status_q;
	assign res.hit          = hit_q;
	assign res.result_value = rv_q;
	assign res.count_now    = 7'(count_q);

	always_comb begin
		rd_addr = mid[ADDR_BITS-1:0];
		wr.en   = 1'b0;
		wr.addr = k_q[ADDR_BITS-1:0];
		wr.data = rd_data;
		case (state_q)
			S_IDLE: begin
				rd_addr = (req.mode == MODE_POP) ? '0 : ADDR_BITS'(req.item_index);
			end
			S_INS: begin
				rd_addr = k_dn[ADDR_BITS-1:0];
				if (k_q == lo_q) begin
					wr.en   = 1'b1;
					wr.data = val_q;
				end
			end
			S_INS_WR: wr.en = 1'b1;
			S_REM:    rd_addr = k_up[ADDR_BITS-1:0];
			S_REM_WR: wr.en = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						mode_q   <= req.mode;
						val_q    <= req.item_value;
						lo_q     <= '0;
						hi_q     <= count_q;
						found_q  <= 1'b0;
						status_q <= ST_DONE;
						hit_q    <= 1'b0;
						rv_q     <= '0;
						case (req.mode)
							MODE_INSERT, MODE_REMOVE, MODE_MEMBER: state_q <= S_SRCH_RD;
							MODE_POP: begin
								if (count_q == '0) begin
									status_q <= ST_REJECT;
									state_q  <= S_FINISH;
								end else begin
									state_q <= S_POP_WAIT;
								end
							end
							MODE_READ: begin
								if (CNT_BITS'(req.item_index) < count_q) begin
									state_q <= S_RD_WAIT;
								end else begin
									status_q <= ST_REJECT;
									state_q  <= S_FINISH;
								end
							end
							MODE_COUNT: state_q <= S_FINISH;
							default: begin
								status_q <= ST_REJECT;
								state_q  <= S_FINISH;
							end
						endcase
					end
				end
				S_SRCH_RD: state_q <= (lo_q == hi_q) ? S_DECIDE : S_SRCH_CMP;
				S_SRCH_CMP: begin
					// Values are distinct, so a hit pins the upper bound at mid.
					if (rd_data < val_q) begin
						lo_q <= mid + CNT_BITS'(1);
					end else begin
						hi_q <= mid;
					end
					if (rd_data == val_q) begin
						found_q <= 1'b1;
					end
					state_q <= S_SRCH_RD;
				end
				S_DECIDE: begin
					state_q <= S_FINISH;
					case (mode_q)
						MODE_INSERT: begin
							if (found_q) begin
								status_q <= ST_REJECT;
							end else if (count_q >= CNT_BITS'(CAPACITY)) begin
								status_q <= ST_FULL;
							end else begin
								k_q     <= count_q;
								state_q <= S_INS;
							end
						end
						MODE_REMOVE: begin
							if (found_q) begin
								k_q     <= lo_q;
								state_q <= S_REM;
							end else begin
								status_q <= ST_REJECT;
							end
						end
						default: hit_q <= found_q;
					endcase
				end
				S_INS: begin
					if (k_q == lo_q) begin
						count_q <= count_q + CNT_BITS'(1);
						state_q <= S_FINISH;
					end else begin
						state_q <= S_INS_WR;
					end
				end
				S_INS_WR: begin
					k_q     <= k_dn;
					state_q <= S_INS;
				end
				S_REM: begin
					if (k_up < count_q) begin
						state_q <= S_REM_WR;
					end else begin
						count_q <= count_q - CNT_BITS'(1);
						state_q <= S_FINISH;
					end
				end
				S_REM_WR: begin
					k_q     <= k_up;
					state_q <= S_REM;
				end
				S_POP_WAIT: begin
					rv_q    <= rd_data;
					k_q     <= '0;
					state_q <= S_REM;
				end
				S_RD_WAIT: begin
					rv_q    <= rd_data;
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`SS_ASSERT(a_count_cap, clk, arst_n, count_q <= CNT_BITS'(CAPACITY), "count above capacity")
	`SS_ASSERT(a_count_move, clk, arst_n, $stable(count_q) || state_q == S_FINISH, "count moved outside finish")
	`SS_ASSERT(a_wr_state, clk, arst_n, !wr.en || state_q == S_INS || state_q == S_INS_WR || state_q == S_REM_WR, "store written outside a shift")
	`SS_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid, "result dropped before taken")

endmodule

/* rtl/core/sorted_set_table.sv */
// Count answers straight from acceptance, read waits for the registered store data; membership
// runs a binary search of about log2(count+1) steps, each a store read and a compare; insert and
// remove add a read and a write per shifted entry; pop reads the head and shifts the rest down.
// Throughput: one word at a time; the sequencer holds a request until its response is handed on.
// The output register frees the sequencer while a finished word waits on the output side.
// Reset (arst_n low, asynchronous) empties the table; the store itself is not cleared.
// ----------------------------------------------------------------------------
// sorted_set_table
// Set of distinct values kept in ascending order in an on-chip store.
// ----------------------------------------------------------------------------
module sorted_set_table
	import sst_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  req_t req,
	input  logic req_valid,
	output logic req_ready,
	output rsp_t rsp,
	output logic rsp_valid,
	input  logic rsp_ready
);

	wr_t                   wr;
	logic [ADDR_BITS-1:0]  rd_addr;
	logic [VALUE_BITS-1:0] rd_data;
	rsp_t                  res;
	logic                  res_valid, res_ready;
	rsp_t                  rsp_q;
	logic                  rsp_valid_q;

	sst_ram u_ram (
		.clk     (clk),
		.wr      (wr),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	sst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.res       (res),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.wr        (wr),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data)
	);

	assign res_ready = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_ready) begin
			rsp_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			rsp_q <= res;
		end
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

endmodule
